### rtl/rrsm_pkg.sv
// Shared types and codes for the request/reply stamp matcher.
// No dependencies; used by rrsm_ram and request_reply_stamp_matcher.
package rrsm_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [1:0] KIND_CLIENT = 2'd0;
  localparam logic [1:0] KIND_SERVER = 2'd1;
  localparam logic [1:0] KIND_TAKE   = 2'd2;

  localparam logic [2:0] STAT_MATCHED  = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_DUP      = 3'd2;
  localparam logic [2:0] STAT_RETURNED = 3'd3;
  localparam logic [2:0] STAT_NONE     = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] stamp_key;
    logic [31:0] server_tag;
    logic [63:0] local_count;
    logic [7:0]  hop_limit;
    logic [31:0] reference_id;
    logic [7:0]  server_stratum;
    logic [1:0]  leap_indicator;
    logic [31:0] delay_root;
    logic [31:0] dispersion_root;
    logic [63:0] receive_time;
    logic [63:0] transmit_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] full_key;
    logic [31:0] full_server_tag;
    logic [63:0] client_count;
    logic [63:0] server_count;
    logic [17:0] quality_bits;
    logic [31:0] full_reference_id;
    logic [31:0] full_delay_root;
    logic [31:0] full_dispersion_root;
    logic [63:0] full_receive_time;
    logic [63:0] full_transmit_time;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] client_count;
    logic [63:0] server_count;
    logic [31:0] server_tag;
    logic [17:0] quality;
    logic [31:0] reference;
    logic [31:0] delay;
    logic [31:0] dispersion;
    logic [63:0] receive;
    logic [63:0] transmit;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_PLACE,
    ST_BEST,
    ST_PURGE
  } state_t;

endpackage

### rtl/rrsm_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on rrsm_pkg for the entry type.
module rrsm_ram #(
  parameter int DEPTH = rrsm_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  rrsm_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output rrsm_pkg::entry_t  rdata
);

  rrsm_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/request_reply_stamp_matcher.sv
// Top level of the request/reply stamp matcher.
// Depends on rrsm_pkg and rrsm_ram.
//
// Use: drive request and raise start; the transfer happens at a clock edge
// where start is high and busy is low. Exactly one result follows per
// transfer, shown on result for one cycle with done high. The receiver
// cannot stall, so done is a single-cycle pulse and must be captured.
// Kind 0/1 store a client or server half keyed by stamp_key; kind 2 takes
// the full stamp with the smallest client count (oldest on ties) and purges
// stale halves; kind 3 returns "none found" at once.
// A half insert scans the entry RAM once. A take scans once to pick the
// stamp and once more to purge; a take that finds nothing ends after the
// first scan. Each scan reads the entry RAM through its single read port,
// one entry per cycle. busy stays high until done.
// Reset clears the valid bits and the entry count; no clearing pass is run.
module request_reply_stamp_matcher #(
  parameter int TABLE_DEPTH = rrsm_pkg::TABLE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  rrsm_pkg::req_t request,
  output logic           busy,
  output logic           done,
  output rrsm_pkg::rsp_t result
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = $bits(rrsm_pkg::rsp_t) - 3;

  rrsm_pkg::state_t state, state_next;
  rrsm_pkg::req_t   item;

  logic [TABLE_DEPTH-1:0] valid;
  logic [IW-1:0]          rank [TABLE_DEPTH];
  logic [CW-1:0]          count;

  logic [IW:0]   idx;
  logic          chk;
  logic [IW-1:0] chk_idx;

  logic             hit_found, free_found;
  logic [IW-1:0]    hit_idx, free_idx, victim_idx;
  rrsm_pkg::entry_t hit_ent;
  logic             best_found;
  logic [IW-1:0]    best_idx;
  logic [IW-1:0]    best_rank;
  rrsm_pkg::entry_t best_ent;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  rrsm_pkg::entry_t ram_wdata, ram_rdata;

  logic scan_end, accept, is_server, full, dup, drop;
  logic c_half, s_half;
  logic [IW-1:0] place_idx;
  rrsm_pkg::entry_t merged;

  assign accept    = start && !busy;
  assign busy      = (state != rrsm_pkg::ST_IDLE);
  assign scan_end  = (idx == (IW+1)'(TABLE_DEPTH)) && !chk;
  assign is_server = (item.kind == rrsm_pkg::KIND_SERVER);
  assign full      = (count == CW'(TABLE_DEPTH));

  rrsm_ram #(.DEPTH(TABLE_DEPTH), .AW(IW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrsm_pkg::ST_IDLE: begin
        if (accept && (request.kind == rrsm_pkg::KIND_CLIENT ||
                       request.kind == rrsm_pkg::KIND_SERVER)) begin
          state_next = rrsm_pkg::ST_FIND;
        end else if (accept && request.kind == rrsm_pkg::KIND_TAKE) begin
          state_next = rrsm_pkg::ST_BEST;
        end
      end
      rrsm_pkg::ST_FIND:  if (scan_end) state_next = rrsm_pkg::ST_PLACE;
      rrsm_pkg::ST_PLACE: state_next = rrsm_pkg::ST_IDLE;
      rrsm_pkg::ST_BEST: begin
        if (scan_end) begin
          state_next = best_found ? rrsm_pkg::ST_PURGE : rrsm_pkg::ST_IDLE;
        end
      end
      rrsm_pkg::ST_PURGE: if (scan_end) state_next = rrsm_pkg::ST_IDLE;
      default: state_next = rrsm_pkg::ST_IDLE;
    endcase
  end

  // placement and merge for half inserts
  always_comb begin
    place_idx = hit_found ? hit_idx : (full ? victim_idx : free_idx);
    dup = hit_found && (is_server ? (hit_ent.server_count != '0)
                                  : (hit_ent.client_count != '0));
    merged = hit_found ? hit_ent : '0;
    merged.key = item.stamp_key;
    if (is_server) begin
      merged.quality      = {item.leap_indicator, item.server_stratum, item.hop_limit};
      merged.reference    = item.reference_id;
      merged.delay        = item.delay_root;
      merged.dispersion   = item.dispersion_root;
      merged.receive      = item.receive_time;
      merged.transmit     = item.transmit_time;
      merged.server_count = item.local_count;
    end else begin
      merged.server_tag   = item.server_tag;
      merged.client_count = item.local_count;
    end
  end

  // purge decision on returned entry
  always_comb begin
    c_half = (ram_rdata.client_count != '0) && (ram_rdata.server_count == '0);
    s_half = (ram_rdata.client_count == '0) && (ram_rdata.server_count != '0);
    drop = (chk_idx == best_idx) ||
           (s_half && ram_rdata.server_count < best_ent.server_count) ||
           (c_half && ram_rdata.client_count < best_ent.client_count &&
            ram_rdata.server_tag == best_ent.server_tag);
  end

  // RAM control
  always_comb begin
    ram_raddr = idx[IW-1:0];
    ram_we    = (state == rrsm_pkg::ST_PLACE) && !dup;
    ram_waddr = place_idx;
    ram_wdata = merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrsm_pkg::ST_IDLE;
      valid <= '0;
      count <= '0;
      done  <= 1'b0;
      chk   <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;

      if (state == rrsm_pkg::ST_FIND || state == rrsm_pkg::ST_BEST ||
          state == rrsm_pkg::ST_PURGE) begin
        if (idx != (IW+1)'(TABLE_DEPTH)) begin
          idx     <= idx + 1'b1;
          chk     <= 1'b1;
          chk_idx <= idx[IW-1:0];
        end else begin
          chk <= 1'b0;
        end
      end

      unique case (state)
        rrsm_pkg::ST_IDLE: begin
          if (accept) begin
            item       <= request;
            idx        <= '0;
            chk        <= 1'b0;
            hit_found  <= 1'b0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            if (request.kind != rrsm_pkg::KIND_CLIENT &&
                request.kind != rrsm_pkg::KIND_SERVER &&
                request.kind != rrsm_pkg::KIND_TAKE) begin
              result <= {rrsm_pkg::STAT_NONE, RW'(0)};
              done   <= 1'b1;
            end
          end
        end
        rrsm_pkg::ST_FIND: begin
          if (chk) begin
            if (valid[chk_idx] && ram_rdata.key == item.stamp_key && !hit_found) begin
              hit_found <= 1'b1;
              hit_idx   <= chk_idx;
              hit_ent   <= ram_rdata;
            end
            if (!valid[chk_idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= chk_idx;
            end
            if (valid[chk_idx] && rank[chk_idx] == IW'(count - 1'b1)) begin
              victim_idx <= chk_idx;
            end
          end
        end
        rrsm_pkg::ST_PLACE: begin
          done <= 1'b1;
          if (dup) begin
            result <= {rrsm_pkg::STAT_DUP, RW'(0)};
          end else if (hit_found) begin
            result <= {rrsm_pkg::STAT_MATCHED, RW'(0)};
          end else begin
            result <= {rrsm_pkg::STAT_INSERTED, RW'(0)};
            for (int j = 0; j < TABLE_DEPTH; j++) begin
              if (valid[j]) rank[j] <= rank[j] + 1'b1;
            end
            valid[place_idx] <= 1'b1;
            rank[place_idx]  <= '0;
            if (!full) count <= count + 1'b1;
          end
        end
        rrsm_pkg::ST_BEST: begin
          if (chk && valid[chk_idx] && ram_rdata.client_count != '0 &&
              ram_rdata.server_count != '0 &&
              (!best_found || ram_rdata.client_count < best_ent.client_count ||
               (ram_rdata.client_count == best_ent.client_count &&
                rank[chk_idx] > best_rank))) begin
            best_found <= 1'b1;
            best_idx   <= chk_idx;
            best_rank  <= rank[chk_idx];
            best_ent   <= ram_rdata;
          end
          if (scan_end) begin
            idx <= '0;
            if (!best_found) begin
              result <= {rrsm_pkg::STAT_NONE, RW'(0)};
              done   <= 1'b1;
            end
          end
        end
        rrsm_pkg::ST_PURGE: begin
          if (chk && valid[chk_idx] && drop) begin
            valid[chk_idx] <= 1'b0;
            for (int j = 0; j < TABLE_DEPTH; j++) begin
              if (valid[j] && rank[j] > rank[chk_idx]) rank[j] <= rank[j] - 1'b1;
            end
            count <= count - 1'b1;
          end
          if (scan_end) begin
            done   <= 1'b1;
            result <= {rrsm_pkg::STAT_RETURNED, best_ent.key, best_ent.server_tag,
                       best_ent.client_count, best_ent.server_count, best_ent.quality,
                       best_ent.reference, best_ent.delay, best_ent.dispersion,
                       best_ent.receive, best_ent.transmit};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
